// File: sv/agsc_pkg.sv
// Shared types, constants and the tanh interpolation table for the gain and soft-clip block.
// No dependencies. Every other file imports this package.
`default_nettype none

package agsc_pkg;

    // Field widths and gain format
    localparam int SAMPLE_W       = 16;
    localparam int GAIN_W         = 15;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int GAIN_MIN       = 1 << GAIN_FRAC_BITS;
    localparam int GAIN_MAX       = 6 << GAIN_FRAC_BITS;
    localparam int BYPASS_MAX     = (1001 * (1 << GAIN_FRAC_BITS)) / 1000;

    // Product p = |sample| * gain, unit 2^ONE_SHIFT
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int PROD_W     = 30;                 // 32768 * 24576 < 2^30
    localparam int PROD5_W    = PROD_W + 3;
    localparam int ONE_SHIFT  = 15 + GAIN_FRAC_BITS;
    localparam int CLIP_LIM   = 4 << ONE_SHIFT;     // 0.8 scaled by 5
    localparam int RES_W      = 15;
    localparam int FULL_SCALE = 32767;
    localparam int LIN_PROD_W = ONE_SHIFT + RES_W;

    // Tanh table addressing
    localparam int TANH_DEPTH = 256;
    localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
    localparam int TANH_ADR_W = TANH_IDX_W + 1;
    localparam int TANH_Q_W   = 17;
    localparam int TANH_ONE   = 65536;
    localparam int WGT_W      = 16;
    localparam int POS_SHIFT  = 18 + GAIN_FRAC_BITS - TANH_IDX_W;
    localparam int WGT_LSB    = POS_SHIFT - WGT_W;

    // Clipped output: floor(32767 * (4*65536 + th) / (5*65536))
    localparam int CLIP_BASE  = 4 * TANH_ONE;
    localparam int Z_W        = 19;
    localparam int ZS_W       = Z_W + 15;
    localparam int Y_W        = 18;
    // floor(y/5) == (y * DIV5_MUL) >> DIV5_SHIFT, exact for y < 2^18
    localparam int DIV5_MUL   = 209716;
    localparam int DIV5_SHIFT = 20;
    localparam int Q_FULL_W   = 2 * Y_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_out;
    } t_out_item;

    // Per-item sideband carried down the pipe
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic                neg;
        logic                last;
        logic                bypass;
        logic                clip;
        logic [RES_W-1:0]    lin_res;
    } t_side;

    // Table position of the tanh argument
    typedef struct packed {
        logic                  sat;
        logic [TANH_IDX_W-1:0] idx;
        logic [WGT_W-1:0]      wgt;
    } t_tap;

    typedef logic [TANH_Q_W-1:0] t_tanh_tab [0:TANH_DEPTH];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Restoring divide, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/TANH_DEPTH) in Q16: odd series at x/256, then eight doubling steps
    function automatic logic [TANH_Q_W-1:0] tanh_q16(input int unsigned k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] a5;
        logic [63:0] t;
        logic [63:0] den;
        logic [63:0] r;
        a  = 64'(k) << (32 - (TANH_IDX_W + 8));
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        a5 = (a3 * a2) >> 30;
        t  = a - udiv64(a3, 64'd3) + udiv64(a5 << 1, 64'd15);
        for (int n = 0; n < 8; n++) begin
            den = Q30_ONE + ((t * t) >> 30);
            t   = udiv64((t << 31) + (den >> 1), den);
            if (t > Q30_ONE) begin
                t = Q30_ONE;
            end
        end
        r = (t + 64'd8192) >> 14;
        if (r > 64'(TANH_ONE)) begin
            r = 64'(TANH_ONE);
        end
        return r[TANH_Q_W-1:0];
    endfunction

    function automatic t_tanh_tab build_tanh_tab();
        t_tanh_tab             tab;
        logic [TANH_Q_W-1:0]   v;
        for (int k = 0; k <= TANH_DEPTH; k++) begin
            v = tanh_q16(k);
            if (k > 0 && v < tab[k-1]) begin
                v = tab[k-1];
            end
            tab[k] = v;
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = build_tanh_tab();

endpackage

`default_nettype wire

// File: sv/agsc_gain_reg.sv
// Gain configuration register with clamp to [1.0, 6.0].
// Depends on agsc_pkg.
`default_nettype none

module agsc_gain_reg
    import agsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [GAIN_W-1:0] i_wdata,
    output logic      [GAIN_W-1:0] o_gain
);

    logic [GAIN_W-1:0] r_gain;
    logic [GAIN_W-1:0] n_gain;

    always_comb begin
        if (i_wdata < GAIN_W'(GAIN_MIN)) begin
            n_gain = GAIN_W'(GAIN_MIN);
        end else if (i_wdata > GAIN_W'(GAIN_MAX)) begin
            n_gain = GAIN_W'(GAIN_MAX);
        end else begin
            n_gain = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_W'(GAIN_MIN);
        end else if (i_we) begin
            r_gain <= n_gain;
        end
    end

    assign o_gain = r_gain;

endmodule

`default_nettype wire

// File: sv/agsc_front.sv
// Front stages: magnitude, gain multiply, clip test, linear result, tanh table position.
// Depends on agsc_pkg.
`default_nettype none

module agsc_front
    import agsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [GAIN_W-1:0] i_gain,
    input  wire logic              i_valid,
    input  wire t_in_item          i_item,
    output logic                   o_valid,
    output t_side                  o_side,
    output t_tap                   o_tap
);

    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    t_side               r_side1;
    t_side               r_side2;
    t_side               r_side3;
    logic [MAG_W-1:0]    r_mag;
    logic [PROD_W-1:0]   r_prod;
    t_tap                r_tap;

    t_side                    n_side1;
    logic [MAG_W-1:0]         n_mag;
    logic [MAG_W+GAIN_W-1:0]  n_prod_full;
    logic [PROD5_W-1:0]       n_prod5;
    logic [PROD5_W-1:0]       n_arg;
    logic [LIN_PROD_W-1:0]    n_lin;
    t_side                    n_side3;
    t_tap                     n_tap;

    // stage 1: sign, magnitude, bypass decision
    always_comb begin
        n_side1.raw     = i_item.sample_in;
        n_side1.neg     = i_item.sample_in[SAMPLE_W-1];
        n_side1.last    = i_item.last_in;
        n_side1.bypass  = (i_gain <= GAIN_W'(BYPASS_MAX));
        n_side1.clip    = 1'b0;
        n_side1.lin_res = '0;
        if (n_side1.neg) begin
            n_mag = {1'b0, ~i_item.sample_in} + MAG_W'(1);
        end else begin
            n_mag = {1'b0, i_item.sample_in};
        end
    end

    // stage 2: p = mag * gain
    assign n_prod_full = (MAG_W+GAIN_W)'(r_mag) * (MAG_W+GAIN_W)'(i_gain);

    // stage 3: 5p against 4*ONE, linear result, table position of 5p - 4*ONE
    always_comb begin
        n_prod5 = PROD5_W'({r_prod, 2'b00}) + PROD5_W'(r_prod);
        n_arg   = n_prod5 - PROD5_W'(CLIP_LIM);
        n_lin   = LIN_PROD_W'(r_prod[ONE_SHIFT-1:0]) * LIN_PROD_W'(FULL_SCALE);
        n_side3 = r_side2;
        n_side3.clip    = (n_prod5 > PROD5_W'(CLIP_LIM));
        n_side3.lin_res = n_lin[LIN_PROD_W-1:ONE_SHIFT];
        n_tap.sat = |n_arg[PROD5_W-1:POS_SHIFT+TANH_IDX_W];
        n_tap.idx = n_arg[POS_SHIFT +: TANH_IDX_W];
        n_tap.wgt = n_arg[WGT_LSB +: WGT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side1 <= n_side1;
        r_mag   <= n_mag;
        r_side2 <= r_side1;
        r_prod  <= n_prod_full[PROD_W-1:0];
        r_side3 <= n_side3;
        r_tap   <= n_tap;
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_tap   = r_tap;

endmodule

`default_nettype wire

// File: sv/agsc_tanh.sv
// Tanh stages: table read of two neighbors, then linear interpolation.
// Depends on agsc_pkg (TANH_TAB).
`default_nettype none

module agsc_tanh
    import agsc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_side         i_side,
    input  wire t_tap          i_tap,
    output logic               o_valid,
    output t_side              o_side,
    output logic [TANH_Q_W-1:0] o_th
);

    logic                  r_v4;
    logic                  r_v5;
    t_side                 r_side4;
    t_side                 r_side5;
    logic                  r_sat;
    logic [TANH_Q_W-1:0]   r_lo;
    logic [TANH_Q_W-1:0]   r_diff;
    logic [WGT_W-1:0]      r_wgt;
    logic [TANH_Q_W-1:0]   r_th;

    logic [TANH_ADR_W-1:0]       n_adr_lo;
    logic [TANH_ADR_W-1:0]       n_adr_hi;
    logic [TANH_Q_W-1:0]         n_lo;
    logic [TANH_Q_W-1:0]         n_hi;
    logic [TANH_Q_W+WGT_W-1:0]   n_scaled;
    logic [TANH_Q_W-1:0]         n_th;

    // stage 4: neighbors T[i], T[i+1]; table is non-decreasing
    always_comb begin
        n_adr_lo = {1'b0, i_tap.idx};
        n_adr_hi = n_adr_lo + TANH_ADR_W'(1);
        n_lo     = TANH_TAB[n_adr_lo];
        n_hi     = TANH_TAB[n_adr_hi];
    end

    // stage 5: th = lo + floor(diff * w / 2^16), 1.0 past the table end
    always_comb begin
        n_scaled = (TANH_Q_W+WGT_W)'(r_diff) * (TANH_Q_W+WGT_W)'(r_wgt);
        if (r_sat) begin
            n_th = TANH_Q_W'(TANH_ONE);
        end else begin
            n_th = r_lo + n_scaled[TANH_Q_W+WGT_W-1:WGT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side4 <= i_side;
        r_sat   <= i_tap.sat;
        r_lo    <= n_lo;
        r_diff  <= n_hi - n_lo;
        r_wgt   <= i_tap.wgt;
        r_side5 <= r_side4;
        r_th    <= n_th;
    end

    assign o_valid = r_v5;
    assign o_side  = r_side5;
    assign o_th    = r_th;

endmodule

`default_nettype wire

// File: sv/agsc_out.sv
// Output stages: clipped level from tanh, divide by five, select, sign and output register.
// Depends on agsc_pkg.
`default_nettype none

module agsc_out
    import agsc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_side               i_side,
    input  wire logic [TANH_Q_W-1:0] i_th,
    output logic                     o_strobe,
    output t_out_item                o_item
);

    logic              r_v6;
    logic              r_v7;
    logic              r_strobe;
    t_side             r_side6;
    t_side             r_side7;
    logic [Y_W-1:0]    r_y;
    logic [RES_W-1:0]  r_q;
    t_out_item         r_item;

    logic [Z_W-1:0]       n_z;
    logic [ZS_W-1:0]      n_zs;
    logic [Q_FULL_W-1:0]  n_q_full;
    logic [RES_W-1:0]     n_res;
    t_out_item            n_item;

    // stage 6: y = floor(32767 * (4*65536 + th) / 65536)
    always_comb begin
        n_z  = Z_W'(CLIP_BASE) + Z_W'(i_th);
        n_zs = ZS_W'({n_z, 15'b0}) - ZS_W'(n_z);
    end

    // stage 7: q = floor(y / 5)
    assign n_q_full = Q_FULL_W'(r_y) * Q_FULL_W'(DIV5_MUL);

    // stage 8: select path, restore sign
    always_comb begin
        n_res = r_side7.clip ? r_q : r_side7.lin_res;
        if (r_side7.bypass) begin
            n_item.sample_out = r_side7.raw;
        end else if (r_side7.neg) begin
            n_item.sample_out = SAMPLE_W'(0) - {1'b0, n_res};
        end else begin
            n_item.sample_out = {1'b0, n_res};
        end
        n_item.last_out = r_side7.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6     <= 1'b0;
            r_v7     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v6     <= i_valid;
            r_v7     <= r_v6;
            r_strobe <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side6 <= i_side;
        r_y     <= n_zs[ZS_W-1:16];
        r_side7 <= r_side6;
        r_q     <= n_q_full[DIV5_SHIFT +: RES_W];
        r_item  <= n_item;
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;

endmodule

`default_nettype wire

// File: sv/audio_gain_soft_clipper_top.sv
// Audio gain stage with tanh soft clip: top level.
// o_strobe rises when the result reaches the output register, and the result is taken
// at the rising edge where o_strobe is high; one item per clock, always.
// busy stays low: an item can be started in every cycle, and results leave on o_strobe with no wait.
// Synchronous active-low reset clears all pipeline valid bits and sets gain to 1.0 (4096).
// Depends on agsc_pkg, agsc_gain_reg, agsc_front, agsc_tanh, agsc_out.
`default_nettype none

module audio_gain_soft_clipper_top
    import agsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item input
    input  wire logic              start,
    output logic                   busy,
    input  wire t_in_item          i_item,
    // result output
    output logic                   o_strobe,
    output t_out_item              o_item,
    // gain register write
    input  wire logic              i_cfg_we,
    input  wire logic [GAIN_W-1:0] i_cfg_wdata
);

    logic [GAIN_W-1:0]   gain;
    logic                front_valid;
    t_side               front_side;
    t_tap                front_tap;
    logic                tanh_valid;
    t_side               tanh_side;
    logic [TANH_Q_W-1:0] tanh_th;

    // Fully pipelined, no back-pressure anywhere.
    assign busy = 1'b0;

    // Gain register, clamped on write. The user must write it only while the pipe is empty (not
    // enforced by the block), so stages 1 and 2 may read it live.
    agsc_gain_reg u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_wdata (i_cfg_wdata),
        .o_gain  (gain)
    );

    // Stages 1-3: |x|, p = |x| * gain, clip test (5p > 4*ONE),
    // linear result p*32767 >> 27, and tanh table index/weight.
    agsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (gain),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .o_valid (front_valid),
        .o_side  (front_side),
        .o_tap   (front_tap)
    );

    // Stages 4-5: tanh from the constant table with linear interpolation.
    agsc_tanh u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_side  (front_side),
        .i_tap   (front_tap),
        .o_valid (tanh_valid),
        .o_side  (tanh_side),
        .o_th    (tanh_th)
    );

    // Stages 6-8: 0.8 + 0.2*tanh scaled to 32767, path select, sign, output register.
    agsc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (tanh_valid),
        .i_side   (tanh_side),
        .i_th     (tanh_th),
        .o_strobe (o_strobe),
        .o_item   (o_item)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for audio_gain_soft_clipper_top: gain boost with tanh soft clip.
// Imports agsc_pkg for the item structs and GAIN_W; the clip predictor builds its own tanh table.

module tb;
    import agsc_pkg::*;

    // Own copy of the gain format and clip constants
    localparam int          GAIN_UNITY   = 4096;          // 1.0
    localparam int          GAIN_CEIL    = 24576;         // 6.0
    localparam int          BYPASS_LIMIT = 4100;          // floor(1.001 * 4096)
    localparam logic [63:0] PROD_ONE     = 64'd1 << 27;   // unit of |sample| * gain
    localparam logic [63:0] Q30_UNITY    = 64'd1 << 30;
    localparam int          LUT_DEPTH    = 256;
    localparam logic [63:0] TANH_UNITY   = 64'd65536;
    localparam int          PIPE_LATENCY = 8;
    localparam int          WATCHDOG_LIMIT = 2000;

    // Gain register copy plus expected results in arrival order
    class clip_scoreboard;
        logic [GAIN_W-1:0] gain;
        logic [16:0]       tanh_lut [0:LUT_DEPTH];
        t_out_item         clipped_q [$];
        int                fail_count;

        function new();
            logic [63:0] a;
            logic [63:0] a2;
            logic [63:0] a3;
            logic [63:0] a5;
            logic [63:0] t;
            logic [63:0] den;
            logic [63:0] r;
            gain       = GAIN_W'(GAIN_UNITY);
            fail_count = 0;
            // tanh(4k/256): odd series at x/256, eight doubling steps, Q16, monotone
            for (int k = 0; k <= LUT_DEPTH; k++) begin
                a  = (64'(k) << 32) / (64'(LUT_DEPTH) << 8);
                a2 = (a * a) >> 30;
                a3 = (a2 * a) >> 30;
                a5 = (a3 * a2) >> 30;
                t  = a - a3 / 64'd3 + (64'd2 * a5) / 64'd15;
                for (int n = 0; n < 8; n++) begin
                    den = Q30_UNITY + ((t * t) >> 30);
                    t   = ((t << 31) + den / 64'd2) / den;
                    if (t > Q30_UNITY) t = Q30_UNITY;
                end
                r = (t + (64'd1 << 13)) >> 14;
                if (r > TANH_UNITY) r = TANH_UNITY;
                if (k > 0 && r < 64'(tanh_lut[k-1])) r = 64'(tanh_lut[k-1]);
                tanh_lut[k] = r[16:0];
            end
        endfunction

        function void set_gain(logic [GAIN_W-1:0] v);
            if (v < GAIN_W'(GAIN_UNITY)) v = GAIN_W'(GAIN_UNITY);
            if (v > GAIN_W'(GAIN_CEIL))  v = GAIN_W'(GAIN_CEIL);
            gain = v;
        endfunction

        function int pending();
            return clipped_q.size();
        endfunction

        // Work out the boosted, soft-clipped sample for one accepted item
        function void note_sample(t_in_item it);
            logic [15:0] raw;
            logic        neg;
            logic [16:0] mag;
            logic [63:0] prod;
            logic [63:0] pos;
            logic [63:0] idx;
            logic [63:0] wgt;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] th;
            logic [63:0] res;
            t_out_item   r;
            raw        = it.sample_in;
            neg        = raw[15];
            mag        = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
            r.last_out = it.last_in;
            if (gain <= GAIN_W'(BYPASS_LIMIT)) begin
                r.sample_out = raw;
            end else begin
                prod = 64'(mag) * 64'(gain);
                if (64'd5 * prod > 64'd4 * PROD_ONE) begin
                    // tanh argument 2.5*(|v|-0.8) mapped onto the table span [0,4)
                    pos = (64'd5 * prod - 64'd4 * PROD_ONE) * 64'(LUT_DEPTH);
                    idx = pos >> 30;
                    if (idx >= 64'(LUT_DEPTH)) begin
                        th = TANH_UNITY;
                    end else begin
                        wgt = (pos & ((64'd1 << 30) - 64'd1)) >> 14;
                        lo  = 64'(tanh_lut[idx[8:0]]);
                        hi  = 64'(tanh_lut[idx[8:0] + 9'd1]);
                        th  = lo + (((hi - lo) * wgt) >> 16);
                    end
                    res = (64'd32767 * (64'd4 * TANH_UNITY + th)) / (64'd5 * TANH_UNITY);
                end else begin
                    res = (prod * 64'd32767) >> 27;
                end
                if (res > 64'd32767) res = 64'd32767;
                r.sample_out = neg ? 16'(-res) : 16'(res);
            end
            clipped_q.push_back(r);
        endfunction

        function void check_result(t_out_item act);
            t_out_item exp_item;
            if (clipped_q.size() == 0) begin
                $error("result with no item outstanding: sample_out %0d last_out %0d",
                       act.sample_out, act.last_out);
                fail_count++;
                return;
            end
            exp_item = clipped_q.pop_front();
            if (act.sample_out !== exp_item.sample_out) begin
                $error("sample_out: expected %0d, got %0d", exp_item.sample_out, act.sample_out);
                fail_count++;
            end
            if (act.last_out !== exp_item.last_out) begin
                $error("last_out: expected %0d, got %0d", exp_item.last_out, act.last_out);
                fail_count++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_item          i_item;
    logic              o_strobe;
    t_out_item         o_item;
    logic              i_cfg_we;
    logic [GAIN_W-1:0] i_cfg_wdata;

    clip_scoreboard sb;
    int             idle_cycles;

    audio_gain_soft_clipper_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge; inputs move only on the falling edge
    always @(posedge i_clk) begin
        if (start && !busy) sb.note_sample(i_item);
        if (o_strobe) sb.check_result(o_item);
    end

    // Watchdog: too long with neither an item taken nor a result out
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One item; the sender may sit idle first. Returns at the accepting edge.
    task automatic drive_sample(input logic signed [15:0] s, input logic l, input int idle_pct);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{sample_in: s, last_in: l};
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait until every outstanding result has come back
    task automatic drain_pipe();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Gain writes only with the pipe empty
    task automatic write_gain(input logic [GAIN_W-1:0] v);
        drain_pipe();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_gain(v);
    endtask

    // Random samples weighted toward the clip knee and the end of the tanh table
    task automatic run_random_phase(input logic [GAIN_W-1:0] g, input int n_items,
                                    input int idle_pct);
        int          pick;
        int          m;
        logic        neg;
        logic [15:0] s;
        write_gain(g);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            neg  = 1'($urandom_range(1));
            if (pick < 45) begin
                s = 16'($urandom);
            end else if (pick < 65) begin
                m = $urandom_range(8191);
                s = neg ? 16'(-m) : 16'(m);
            end else if (pick < 85) begin
                // knee at |v| = 0.8, table end at |v| = 2.4
                m = ($urandom_range(1) ? 107374182 : 322122547) / int'(sb.gain);
                m = m + $urandom_range(6) - 3;
                if (m > 32768) m = 32768;
                if (!neg && m > 32767) m = 32767;
                s = neg ? 16'(-m) : 16'(m);
            end else begin
                case ($urandom_range(5))
                    0: s = 16'sd32767;
                    1: s = -16'sd32768;
                    2: s = 16'sd0;
                    3: s = 16'sd1;
                    4: s = -16'sd1;
                    default: s = -16'sd32767;
                endcase
            end
            drive_sample(s, 1'($urandom_range(1)), idle_pct);
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_cycles = 0;
        sb          = new();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gain is 1.0: straight pass-through, extremes and last flag both ways
        drive_sample(16'sd32767, 1'b1, 0);
        drive_sample(-16'sd32768, 1'b0, 0);
        drive_sample(16'sd0, 1'b0, 0);
        drive_sample(-16'sd1, 1'b1, 0);

        // Write below 1.0 clamps up; 4100 is the top of the bypass band
        write_gain('0);
        drive_sample(16'sd12345, 1'b0, 0);
        write_gain(GAIN_W'(BYPASS_LIMIT));
        drive_sample(-16'sd100, 1'b1, 0);

        // Smallest real boost: knee between 26182 and 26183
        write_gain(GAIN_W'(BYPASS_LIMIT + 1));
        drive_sample(16'sd26182, 1'b0, 0);
        drive_sample(16'sd26183, 1'b0, 0);
        drive_sample(16'sd26184, 1'b1, 0);
        drive_sample(-16'sd26184, 1'b0, 0);
        drive_sample(16'sd32767, 1'b0, 0);

        // All-ones write clamps to 6.0: knee at 4369/4370, tanh saturates past 13107
        write_gain('1);
        drive_sample(16'sd4369, 1'b0, 0);
        drive_sample(-16'sd4370, 1'b1, 0);
        drive_sample(16'sd13107, 1'b0, 0);
        drive_sample(16'sd13108, 1'b0, 0);
        drive_sample(-16'sd32768, 1'b1, 0);
        drive_sample(16'sd32767, 1'b0, 0);
        drive_sample(16'sd1, 1'b0, 0);
        drive_sample(-16'sd1, 1'b1, 0);

        // Random part: sender idles 38%, then 69%, then never
        run_random_phase(GAIN_W'(BYPASS_LIMIT + 1), 200, 38);
        run_random_phase(GAIN_W'($urandom_range(GAIN_CEIL - 1, BYPASS_LIMIT + 2)), 200, 38);
        run_random_phase(GAIN_W'(GAIN_CEIL), 200, 69);
        run_random_phase(GAIN_W'($urandom_range(32767)), 200, 69);
        run_random_phase(GAIN_W'(BYPASS_LIMIT), 100, 0);
        run_random_phase(GAIN_W'($urandom_range(GAIN_CEIL, BYPASS_LIMIT + 1)), 300, 0);

        drain_pipe();
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: audio_gain_soft_clipper_top.f
sv/agsc_pkg.sv
sv/agsc_gain_reg.sv
sv/agsc_front.sv
sv/agsc_tanh.sv
sv/agsc_out.sv
sv/audio_gain_soft_clipper_top.sv
sim/tb.sv
